// ----- rtl/sma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants of the stack machine arithmetic unit
// Stack size, instruction and status codes, cell commands and the divider
// request bundle.
// ----------------------------------------------------------------------------
package sma_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int DEPTH_OUT_W = 9;

    // instruction codes
    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_SWAP = 3'd1,
        ACT_ADD  = 3'd2,
        ACT_SUB  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_MUL  = 3'd5,
        ACT_MOD  = 3'd6
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_SHORT   = 2'd1,
        STAT_DIVZERO = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    // per-cell shift command
    typedef enum logic [1:0] {
        CELL_HOLD     = 2'd0,
        CELL_SHIFT_DN = 2'd1,   // take the word of the cell above (toward top)
        CELL_SHIFT_UP = 2'd2    // take the word of the cell below
    } cell_cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_WB   = 2'd2
    } state_t;

    // divider request
    typedef struct packed {
        logic start;
        logic is_mod;
    } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/sma_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_cell: one stack entry
// Holds one word and loads from the neighbor above or below on command.
// ----------------------------------------------------------------------------
module sma_cell (
    input  wire logic                       aclk,
    input  wire sma_pkg::cell_cmd_t         cmd,
    input  wire logic [sma_pkg::WORD_W-1:0] prev_data,
    input  wire logic [sma_pkg::WORD_W-1:0] next_data,
    output logic      [sma_pkg::WORD_W-1:0] data
);
    import sma_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // shift selection
    always_comb begin
        data_next = data_reg;
        unique case (cmd)
            CELL_SHIFT_DN: data_next = prev_data;
            CELL_SHIFT_UP: data_next = next_data;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- rtl/sma_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_div: iterative signed divider
// Restoring radix-2 division of magnitudes, one quotient bit per cycle, then
// a sign fix. Gives the truncated quotient or the dividend-signed remainder.
// ----------------------------------------------------------------------------
module sma_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sma_pkg::div_req_t          req,
    input  wire logic [sma_pkg::WORD_W-1:0] dividend,
    input  wire logic [sma_pkg::WORD_W-1:0] divisor,
    output logic                            done,
    output logic      [sma_pkg::WORD_W-1:0] result
);
    import sma_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic              mod_reg, mod_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic [WORD_W:0]   rem_sh;
    logic              ge;
    logic [WORD_W-1:0] rem_step;

    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    // one restoring step
    assign rem_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_step = ge ? WORD_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[WORD_W-1:0];

    always_comb begin
        busy_next   = busy_reg;
        fix_next    = 1'b0;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        qneg_next   = qneg_reg;
        rneg_next   = rneg_reg;
        mod_next    = mod_reg;
        result_next = result_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = magnitude(dividend);
            dvs_next  = magnitude(divisor);
            qneg_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rneg_next = dividend[WORD_W-1];
            mod_next  = req.is_mod;
        end else if (busy_reg) begin
            rem_next = rem_step;
            quo_next = {quo_reg[WORD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            // sign fix
            done_next = 1'b1;
            if (mod_reg) begin
                result_next = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
            end else begin
                result_next = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        qneg_reg   <= qneg_next;
        rneg_reg   <= rneg_next;
        mod_reg    <= mod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/stack_machine_alu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_alu_core: operand stack with two-operand arithmetic
// Signed 32-bit stack held in a chain of shift cells; push, swap, add, sub,
// mul, div and mod, one status beat per instruction.
// ----------------------------------------------------------------------------
// The stack lives in a row of STACK_DEPTH shift cells: cell 0 is the top,
// cell 1 the second entry, and a push or pop moves every word one cell along
// in a single cycle. Push, swap, errors and the unused code finish in the
// accept cycle. Add, sub and mul register their result and write it back
// in the next cycle. Div and mod run through the radix-2 divider, one
// quotient bit per cycle, through a start, 32 steps, a sign fix, taking the
// divider result and write-back. One instruction is in work at a time; the
// result beat sits in an output register, and a new instruction is taken
// once that register is empty or being drained. Stack words are not cleared
// at reset; the entry count, the sequencer state and the beat valid flag are.
// ----------------------------------------------------------------------------
module stack_machine_alu_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [2:0]                 s_action,
    input  wire logic signed [31:0]         s_push_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [1:0]                 m_status,
    output logic signed [31:0]              m_top_value,
    output logic      [sma_pkg::DEPTH_OUT_W-1:0] m_stack_depth
);
    import sma_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [WORD_W-1:0]      m_top_reg, m_top_next;
    logic [DEPTH_OUT_W-1:0] m_depth_reg, m_depth_next;

    cell_cmd_t         cmd0, cmd1, cmd_rest;
    logic [WORD_W-1:0] head_data;
    logic [WORD_W-1:0] cell_data [STACK_DEPTH];

    logic [WORD_W-1:0] top_word, sec_word, cur_top, push_word;
    logic              is_full, is_short, accept;

    div_req_t          div_req;
    logic              div_done;
    logic [WORD_W-1:0] div_result;

    assign top_word  = cell_data[0];
    assign sec_word  = cell_data[1];
    assign push_word = $unsigned(s_push_value);
    assign is_full   = cnt_reg == CNT_W'(STACK_DEPTH);
    assign is_short  = cnt_reg < CNT_W'(2);
    assign cur_top   = (cnt_reg == '0) ? '0 : top_word;
    assign accept    = s_valid && s_ready;

    // stack cells
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        cell_cmd_t         c_cmd;
        logic [WORD_W-1:0] c_prev, c_next;
        if (i == 0) begin : g_head
            assign c_cmd  = cmd0;
            assign c_prev = head_data;
        end else if (i == 1) begin : g_second
            assign c_cmd  = cmd1;
            assign c_prev = cell_data[i-1];
        end else begin : g_body
            assign c_cmd  = cmd_rest;
            assign c_prev = cell_data[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign c_next = '0;
        end else begin : g_link
            assign c_next = cell_data[i+1];
        end
        sma_cell u_cell (
            .aclk      (aclk),
            .cmd       (c_cmd),
            .prev_data (c_prev),
            .next_data (c_next),
            .data      (cell_data[i])
        );
    end

    // divider
    sma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (sec_word),
        .divisor  (top_word),
        .done     (div_done),
        .result   (div_result)
    );

    // sequencer: next state, cell commands and result beat
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        cmd0          = CELL_HOLD;
        cmd1          = CELL_HOLD;
        cmd_rest      = CELL_HOLD;
        head_data     = push_word;
        div_req       = '0;
        s_ready       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (accept) begin
                    // default beat: stack unchanged
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_top_next    = cur_top;
                    m_depth_next  = DEPTH_OUT_W'(cnt_reg);
                    case (action_t'(s_action))
                        ACT_PUSH: begin
                            if (is_full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                cmd0         = CELL_SHIFT_DN;
                                cmd1         = CELL_SHIFT_DN;
                                cmd_rest     = CELL_SHIFT_DN;
                                cnt_next     = cnt_reg + 1'b1;
                                m_top_next   = push_word;
                                m_depth_next = DEPTH_OUT_W'(cnt_next);
                            end
                        end
                        ACT_SWAP: begin
                            if (is_short) begin
                                m_status_next = STAT_SHORT;
                            end else begin
                                cmd0       = CELL_SHIFT_UP;
                                cmd1       = CELL_SHIFT_DN;
                                m_top_next = sec_word;
                            end
                        end
                        ACT_ADD, ACT_SUB, ACT_MUL: begin
                            if (is_short) begin
                                m_status_next = STAT_SHORT;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = S_WB;
                                if (action_t'(s_action) == ACT_ADD) begin
                                    res_next = sec_word + top_word;
                                end else if (action_t'(s_action) == ACT_SUB) begin
                                    res_next = sec_word - top_word;
                                end else begin
                                    res_next = sec_word * top_word;
                                end
                            end
                        end
                        ACT_DIV, ACT_MOD: begin
                            if (is_short) begin
                                m_status_next = STAT_SHORT;
                            end else if (top_word == '0) begin
                                m_status_next = STAT_DIVZERO;
                            end else begin
                                m_valid_next   = 1'b0;
                                div_req.start  = 1'b1;
                                div_req.is_mod = action_t'(s_action) == ACT_MOD;
                                state_next     = S_DIV;
                            end
                        end
                        default: begin
                            // unused code: no operation
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_result;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                // pop and replace the new top with the result
                head_data     = res_reg;
                cmd0          = CELL_SHIFT_DN;
                cmd1          = CELL_SHIFT_UP;
                cmd_rest      = CELL_SHIFT_UP;
                cnt_next      = cnt_reg - 1'b1;
                m_valid_next  = 1'b1;
                m_status_next = STAT_OK;
                m_top_next    = res_reg;
                m_depth_next  = DEPTH_OUT_W'(cnt_next);
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_value   = $signed(m_top_reg);
    assign m_stack_depth = m_depth_reg;

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack size");

    a_wb_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WB |-> !m_valid_reg)
        else $error("write-back while a result beat is pending");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_wb_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WB |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("write-back did not pop one entry");

endmodule

`default_nettype wire
